// File: hw/rtl/ufsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ufsr_pkg;

   // Field and datapath widths
   localparam int DEN_BITS  = 16;
   localparam int SUM_BITS  = 32;
   localparam int IN_BITS   = 16;
   localparam int OUT_BITS  = 32;
   localparam int ST_BITS   = 2;
   // num*dp + denp needs one bit beyond the product
   localparam int WIDE_BITS = SUM_BITS + DEN_BITS + 1;
   localparam int PROD_BITS = SUM_BITS + DEN_BITS;
   localparam int CNT_BITS  = $clog2(WIDE_BITS + 1);
   localparam int K_BITS    = $clog2(WIDE_BITS);

   // Result status codes
   localparam logic [ST_BITS-1:0] STATUS_OK   = 2'd0;
   localparam logic [ST_BITS-1:0] STATUS_OVF  = 2'd1;
   localparam logic [ST_BITS-1:0] STATUS_ZERO = 2'd2;

   // GCD operand selection
   localparam logic GCD_G1 = 1'b0;   // gcd(den, d)
   localparam logic GCD_G2 = 1'b1;   // gcd(den, num*dp + denp)

   // Divider operand selection
   localparam logic [1:0] DIV_DP   = 2'd0;   // d / g1
   localparam logic [1:0] DIV_DENP = 2'd1;   // den / g1
   localparam logic [1:0] DIV_QN   = 2'd2;   // sum / g2
   localparam logic [1:0] DIV_QD   = 2'd3;   // den / g2

   typedef struct packed {
      logic       load_req;
      logic       gcd_start;
      logic       gcd_latch;
      logic       gcd_op;
      logic       div_start;
      logic       div_latch;
      logic [1:0] div_op;
      logic       calc_sum;
      logic       calc_prod;
      logic       commit;
      logic       set_zero;
      logic       set_ovf;
      logic       emit;
   } ufsr_cmd_type;

   typedef struct packed {
      logic gcd_done;
      logic div_done;
      logic d_zero;
      logic err_pending;
      logic last;
      logic overflow;
      logic out_free;
   } ufsr_stat_type;

endpackage

`default_nettype wire

// File: hw/rtl/ufsr_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ufsr_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ufsr_pkg::WIDE_BITS-1:0] dividend,
   input  wire logic [ufsr_pkg::SUM_BITS-1:0]  divisor,
   output logic                               done,
   output logic [ufsr_pkg::WIDE_BITS-1:0]     quotient
);
   import ufsr_pkg::*;

   logic [WIDE_BITS-1:0] quo_ff, quo_in;
   logic [SUM_BITS-1:0]  rem_ff, rem_in;
   logic [SUM_BITS-1:0]  dv_ff, dv_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [SUM_BITS:0]    shifted;
   logic                 take;

   // Restoring division, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[WIDE_BITS-1]};
      take    = shifted >= {1'b0, dv_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dv_in   = divisor;
         cnt_in  = CNT_BITS'(WIDE_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take ? SUM_BITS'(shifted - {1'b0, dv_ff}) : SUM_BITS'(shifted);
         quo_in = {quo_ff[WIDE_BITS-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ufsr_gcd.sv
`timescale 1ns / 1ps
`default_nettype none

module ufsr_gcd (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ufsr_pkg::WIDE_BITS-1:0] op_a,
   input  wire logic [ufsr_pkg::WIDE_BITS-1:0] op_b,
   output logic                               done,
   output logic [ufsr_pkg::SUM_BITS-1:0]      result
);
   import ufsr_pkg::*;

   logic [WIDE_BITS-1:0] a_ff, a_in;
   logic [WIDE_BITS-1:0] b_ff, b_in;
   logic [K_BITS-1:0]    k_ff, k_in;
   logic [SUM_BITS-1:0]  res_ff, res_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic                 fin;
   logic [WIDE_BITS-1:0] gsh;

   // Binary GCD: one shift or subtract-and-shift per cycle
   always_comb begin
      fin     = (a_ff == '0) || (b_ff == '0);
      gsh     = (a_ff | b_ff) << k_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      res_in  = res_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fin) begin
            // one operand is zero, the other holds the odd part
            res_in  = SUM_BITS'(gsh);
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in = (a_ff - b_ff) >> 1;
         end else begin
            b_in = (b_ff - a_ff) >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      k_ff   <= k_in;
      res_ff <= res_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ufsr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ufsr_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [ufsr_pkg::IN_BITS-1:0] req_term_denominator,
   input  wire logic                         req_last_term,
   input  wire ufsr_pkg::ufsr_cmd_type       cmd,
   output ufsr_pkg::ufsr_stat_type           stat,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [ufsr_pkg::OUT_BITS-1:0]     rsp_sum_numerator,
   output logic [ufsr_pkg::OUT_BITS-1:0]     rsp_sum_denominator,
   output logic [ufsr_pkg::ST_BITS-1:0]      rsp_status
);
   import ufsr_pkg::*;

   // Running sum and error
   logic [SUM_BITS-1:0]  num_ff, num_in;
   logic [SUM_BITS-1:0]  den_ff, den_in;
   logic [ST_BITS-1:0]   err_ff, err_in;
   // Current term and intermediate values
   logic [DEN_BITS-1:0]  d_ff;
   logic                 last_ff;
   logic [SUM_BITS-1:0]  g1_ff, g2_ff;
   logic [DEN_BITS-1:0]  dp_ff;
   logic [SUM_BITS-1:0]  denp_ff, qd_ff;
   logic [WIDE_BITS-1:0] nsum_ff, qn_ff;
   logic [PROD_BITS-1:0] prod_ff;
   // Output register
   logic                 rv_ff, rv_in;
   logic [OUT_BITS-1:0]  rnum_ff, rden_ff;
   logic [ST_BITS-1:0]   rst_ff;

   logic [PROD_BITS-1:0] mul_nd;
   logic [PROD_BITS-1:0] mul_qd;
   logic [WIDE_BITS-1:0] gcd_b;
   logic [WIDE_BITS-1:0] div_dividend;
   logic [SUM_BITS-1:0]  div_divisor;
   logic                 gcd_done, div_done;
   logic [SUM_BITS-1:0]  gcd_result;
   logic [WIDE_BITS-1:0] div_quotient;

   assign gcd_b = (cmd.gcd_op == GCD_G1) ? WIDE_BITS'(d_ff) : nsum_ff;

   always_comb begin
      case (cmd.div_op)
         DIV_DP: begin
            div_dividend = WIDE_BITS'(d_ff);
            div_divisor  = g1_ff;
         end
         DIV_DENP: begin
            div_dividend = WIDE_BITS'(den_ff);
            div_divisor  = g1_ff;
         end
         DIV_QN: begin
            div_dividend = nsum_ff;
            div_divisor  = g2_ff;
         end
         default: begin
            div_dividend = WIDE_BITS'(den_ff);
            div_divisor  = g2_ff;
         end
      endcase
   end

   ufsr_gcd u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.gcd_start),
      .op_a   (WIDE_BITS'(den_ff)),
      .op_b   (gcd_b),
      .done   (gcd_done),
      .result (gcd_result)
   );

   ufsr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign mul_nd = PROD_BITS'(num_ff) * PROD_BITS'(dp_ff);
   assign mul_qd = PROD_BITS'(qd_ff) * PROD_BITS'(dp_ff);

   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      err_in = err_ff;
      if (cmd.commit) begin
         num_in = SUM_BITS'(qn_ff);
         den_in = SUM_BITS'(prod_ff);
      end
      if (cmd.set_zero) err_in = STATUS_ZERO;
      if (cmd.set_ovf)  err_in = STATUS_OVF;
      if (cmd.emit) begin
         num_in = '0;
         den_in = SUM_BITS'(1);
         err_in = STATUS_OK;
      end
   end

   always_comb begin
      rv_in = rsp_stall ? rv_ff : 1'b0;
      if (cmd.emit) rv_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         d_ff    <= DEN_BITS'(req_term_denominator);
         last_ff <= req_last_term;
      end
      if (cmd.gcd_latch) begin
         if (cmd.gcd_op == GCD_G1) g1_ff <= gcd_result;
         else                      g2_ff <= gcd_result;
      end
      if (cmd.div_latch) begin
         case (cmd.div_op)
            DIV_DP:   dp_ff   <= DEN_BITS'(div_quotient);
            DIV_DENP: denp_ff <= SUM_BITS'(div_quotient);
            DIV_QN:   qn_ff   <= div_quotient;
            default:  qd_ff   <= SUM_BITS'(div_quotient);
         endcase
      end
      if (cmd.calc_sum)  nsum_ff <= WIDE_BITS'(mul_nd) + WIDE_BITS'(denp_ff);
      if (cmd.calc_prod) prod_ff <= mul_qd;
      if (cmd.emit) begin
         rnum_ff <= (err_ff != STATUS_OK) ? '0 : OUT_BITS'(num_ff);
         rden_ff <= (err_ff != STATUS_OK) ? OUT_BITS'(1) : OUT_BITS'(den_ff);
         rst_ff  <= err_ff;
      end
      if (reset) begin
         num_ff <= '0;
         den_ff <= SUM_BITS'(1);
         err_ff <= STATUS_OK;
         rv_ff  <= 1'b0;
      end else begin
         num_ff <= num_in;
         den_ff <= den_in;
         err_ff <= err_in;
         rv_ff  <= rv_in;
      end
   end

   always_comb begin
      stat.gcd_done    = gcd_done;
      stat.div_done    = div_done;
      stat.d_zero      = (d_ff == '0);
      stat.err_pending = (err_ff != STATUS_OK);
      stat.last        = last_ff;
      stat.overflow    = (qn_ff[WIDE_BITS-1:SUM_BITS] != '0)
                      || (prod_ff[PROD_BITS-1:SUM_BITS] != '0);
      stat.out_free    = !rv_ff || !rsp_stall;
   end

   assign rsp_valid           = rv_ff;
   assign rsp_sum_numerator   = rnum_ff;
   assign rsp_sum_denominator = rden_ff;
   assign rsp_status          = rst_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ufsr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ufsr_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire ufsr_pkg::ufsr_stat_type stat,
   output ufsr_pkg::ufsr_cmd_type       cmd
);
   import ufsr_pkg::*;

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_CHECK     = 5'd1;
   localparam logic [4:0] S_G1_WAIT   = 5'd2;
   localparam logic [4:0] S_DP_GO     = 5'd3;
   localparam logic [4:0] S_DP_WAIT   = 5'd4;
   localparam logic [4:0] S_DENP_GO   = 5'd5;
   localparam logic [4:0] S_DENP_WAIT = 5'd6;
   localparam logic [4:0] S_SUM       = 5'd7;
   localparam logic [4:0] S_G2_GO     = 5'd8;
   localparam logic [4:0] S_G2_WAIT   = 5'd9;
   localparam logic [4:0] S_QN_GO     = 5'd10;
   localparam logic [4:0] S_QN_WAIT   = 5'd11;
   localparam logic [4:0] S_QD_GO     = 5'd12;
   localparam logic [4:0] S_QD_WAIT   = 5'd13;
   localparam logic [4:0] S_PROD      = 5'd14;
   localparam logic [4:0] S_COMMIT    = 5'd15;
   localparam logic [4:0] S_FINISH    = 5'd16;
   localparam logic [4:0] S_EMIT      = 5'd17;

   logic [4:0] state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            // skip the term once the set has an error
            if (stat.err_pending) begin
               state_in = S_FINISH;
            end else if (stat.d_zero) begin
               cmd.set_zero = 1'b1;
               state_in     = S_FINISH;
            end else begin
               cmd.gcd_start = 1'b1;
               cmd.gcd_op    = GCD_G1;
               state_in      = S_G1_WAIT;
            end
         end
         S_G1_WAIT: begin
            cmd.gcd_op = GCD_G1;
            if (stat.gcd_done) begin
               cmd.gcd_latch = 1'b1;
               state_in      = S_DP_GO;
            end
         end
         S_DP_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_DP;
            state_in      = S_DP_WAIT;
         end
         S_DP_WAIT: begin
            cmd.div_op = DIV_DP;
            if (stat.div_done) begin
               cmd.div_latch = 1'b1;
               state_in      = S_DENP_GO;
            end
         end
         S_DENP_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_DENP;
            state_in      = S_DENP_WAIT;
         end
         S_DENP_WAIT: begin
            cmd.div_op = DIV_DENP;
            if (stat.div_done) begin
               cmd.div_latch = 1'b1;
               state_in      = S_SUM;
            end
         end
         S_SUM: begin
            cmd.calc_sum = 1'b1;
            state_in     = S_G2_GO;
         end
         S_G2_GO: begin
            cmd.gcd_start = 1'b1;
            cmd.gcd_op    = GCD_G2;
            state_in      = S_G2_WAIT;
         end
         S_G2_WAIT: begin
            cmd.gcd_op = GCD_G2;
            if (stat.gcd_done) begin
               cmd.gcd_latch = 1'b1;
               state_in      = S_QN_GO;
            end
         end
         S_QN_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_QN;
            state_in      = S_QN_WAIT;
         end
         S_QN_WAIT: begin
            cmd.div_op = DIV_QN;
            if (stat.div_done) begin
               cmd.div_latch = 1'b1;
               state_in      = S_QD_GO;
            end
         end
         S_QD_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_QD;
            state_in      = S_QD_WAIT;
         end
         S_QD_WAIT: begin
            cmd.div_op = DIV_QD;
            if (stat.div_done) begin
               cmd.div_latch = 1'b1;
               state_in      = S_PROD;
            end
         end
         S_PROD: begin
            cmd.calc_prod = 1'b1;
            state_in      = S_COMMIT;
         end
         S_COMMIT: begin
            // drop the term and flag it if the reduced sum does not fit
            if (stat.overflow) cmd.set_ovf = 1'b1;
            else               cmd.commit  = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            state_in = stat.last ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            // hold until the output register can take the result
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/unit_fraction_sum_reducer_unit.sv
// Unit fraction sum reducer.
// Input channel (req_): one term per item, a denominator d and a last-term
// flag. The block adds 1/d to a running sum kept as a reduced fraction.
// Result channel (rsp_): one item per set, sent after the term that carries
// the last-term flag: reduced numerator, denominator and status (0 ok,
// 1 overflow past the sum width, 2 zero denominator). After an error the rest
// of the set is ignored and the result reads 0/1 with the error status.
// Throughput: one term at a time. A normal term takes two binary GCD runs
// (one subtract or shift a cycle) and four restoring divisions on the
// shared divider, plus sequencing states. A zero or skipped term goes
// straight from the check state to the finish state. A last term also
// passes the emit state; its result goes valid in the cycle where the
// input reopens.
// req_stall is low only while the controller is idle.
// Stall: the result waits in an output register; the block keeps taking terms
// of the next set and only holds if a second result is ready before the
// first one has been taken.
// Reset: synchronous, active high; clears the sum to 0/1, the status to ok
// and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module unit_fraction_sum_reducer_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [ufsr_pkg::IN_BITS-1:0] req_term_denominator,
   input  wire logic                         req_last_term,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [ufsr_pkg::OUT_BITS-1:0]     rsp_sum_numerator,
   output logic [ufsr_pkg::OUT_BITS-1:0]     rsp_sum_denominator,
   output logic [ufsr_pkg::ST_BITS-1:0]      rsp_status
);
   import ufsr_pkg::*;

   // command and status between sequencer and datapath
   ufsr_cmd_type  cmd;
   ufsr_stat_type stat;

   ufsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ufsr_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_term_denominator (req_term_denominator),
      .req_last_term        (req_last_term),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_sum_numerator    (rsp_sum_numerator),
      .rsp_sum_denominator  (rsp_sum_denominator),
      .rsp_status           (rsp_status)
   );

endmodule

`default_nettype wire
